/* hdl/line_follow_junction_sequencer_core_assert.svh */
// ----------------------------------------------------------------------------
// line_follow_junction_sequencer_core_assert.svh
// assertion macros for the line follow junction sequencer, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_JUNCTION_SEQUENCER_CORE_ASSERT_SVH
`define LINE_FOLLOW_JUNCTION_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LFJS_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lfjs assertion failed");
// next-cycle implication
`define LFJS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lfjs assertion failed");
`else
`define LFJS_ASSERT(lbl, clk, rstn, ante, cons)
`define LFJS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hdl/lfjs_pkg.sv */
// ----------------------------------------------------------------------------
// lfjs_pkg
// shared types and constants of the line follow junction sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lfjs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BLIND  = 3'd1,
    PH_SEEK   = 3'd2,
    PH_SETTLE = 3'd3,
    PH_FOLLOW = 3'd4,
    PH_CENTER = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    DR_STOP  = 2'd0,
    DR_ADV   = 2'd1,
    DR_RIGHT = 2'd2,
    DR_LEFT  = 2'd3
  } drive_t;

  // command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_FWD   = 3'd1;
  localparam logic [2:0] CMD_RIGHT = 3'd2;
  localparam logic [2:0] CMD_LEFT  = 3'd3;
  localparam logic [2:0] CMD_ESTOP = 3'd4;

  // register indexes
  localparam logic [2:0] REG_TARGET_FORWARD     = 3'd0;
  localparam logic [2:0] REG_TARGET_AFTER_RIGHT = 3'd1;
  localparam logic [2:0] REG_TARGET_MARKERS     = 3'd2;
  localparam logic [2:0] REG_SPEED_FAST         = 3'd3;
  localparam logic [2:0] REG_SPEED_SLOW         = 3'd4;
  localparam logic [2:0] REG_SPIN_SPEED         = 3'd5;
  localparam logic [2:0] REG_SPEED_FLOOR        = 3'd6;
  localparam logic [2:0] REG_BLIND_MS           = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam int STEP_DOWN  = 5;
  localparam int TURN_BOOST = 10;
  localparam int CENTER_MS  = 110;
  localparam int SETTLE_MS  = 200;

  typedef struct packed {
    logic [3:0] target_forward;
    logic [3:0] target_after_right;
    logic [3:0] target_markers;
    logic [7:0] speed_fast;
    logic [7:0] speed_slow;
    logic [7:0] spin_speed;
    logic [7:0] speed_floor;
    logic [7:0] blind_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    target_forward:     4'd5,
    target_after_right: 4'd2,
    target_markers:     4'd3,
    speed_fast:         8'd60,
    speed_slow:         8'd40,
    spin_speed:         8'd60,
    speed_floor:        8'd35,
    blind_ms:           8'd150
  };

  // follow speeds handed from the speed unit to the sequencer
  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] boosted;
  } speed_pair_t;

endpackage

`default_nettype wire

/* hdl/lfjs_in_if.sv */
// ----------------------------------------------------------------------------
// lfjs_in_if
// sensor tick channel: command, three line sensors and millisecond strobe
// ----------------------------------------------------------------------------
`default_nettype none

interface lfjs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       sense_left;
  logic       sense_mid;
  logic       sense_right;
  logic       ms_strobe;

  modport source (
    output valid, cmd, sense_left, sense_mid, sense_right, ms_strobe,
    input  ready
  );
  modport sink (
    input  valid, cmd, sense_left, sense_mid, sense_right, ms_strobe,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/lfjs_out_if.sv */
// ----------------------------------------------------------------------------
// lfjs_out_if
// result channel: drive command, speed, phase, count and abort flag
// ----------------------------------------------------------------------------
`default_nettype none

interface lfjs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] drive;
  logic [7:0] drive_speed;
  logic [2:0] phase_now;
  logic [3:0] crossed;
  logic       aborted;

  modport source (
    output valid, drive, drive_speed, phase_now, crossed, aborted,
    input  ready
  );
  modport sink (
    input  valid, drive, drive_speed, phase_now, crossed, aborted,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/lfjs_speed.sv */
// ----------------------------------------------------------------------------
// lfjs_speed
// follow speed: start speed less a step per count, floored, plus turn boost
// ----------------------------------------------------------------------------
`default_nettype none

module lfjs_speed
  import lfjs_pkg::*;
#(
  parameter int COUNT_BITS = 4
) (
  input  wire logic [7:0]            start_speed,
  input  wire logic [7:0]            floor_speed,
  input  wire logic [COUNT_BITS-1:0] count,
  output speed_pair_t                speeds
);

  // count * 5 stays below 2^11 for counts up to 8 bits
  logic [10:0] offset;
  logic [10:0] diff;
  logic        use_floor;
  logic [8:0]  boost_sum;

  assign offset    = 11'(count) * 11'(STEP_DOWN);
  assign diff      = 11'(start_speed) - offset;
  assign use_floor = (offset > 11'(start_speed)) || (diff < 11'(floor_speed));

  assign speeds.cur = use_floor ? floor_speed : diff[7:0];

  // saturate at full scale
  assign boost_sum      = 9'(speeds.cur) + 9'(TURN_BOOST);
  assign speeds.boosted = boost_sum[8] ? 8'hFF : boost_sum[7:0];

endmodule

`default_nettype wire

/* hdl/line_follow_junction_sequencer_core.sv */
// ----------------------------------------------------------------------------
// line_follow_junction_sequencer_core
// line follower run sequencer with junction counting and timed rotations
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one item per sensor tick (cmd, three line sensors, ms strobe)
//   out_ch : one item per input item (drive, drive_speed, phase_now,
//            crossed, aborted), in order
//   cfg_*  : plain write port, register i at index i, written while idle
// timing
//   an item accepted at an edge has its result valid right after that edge;
//   one item per cycle is sustained while out_ch.ready stays high, with a
//   single state update per tick
//   the result sits in the state registers themselves; a new item is taken
//   in the same cycle the waiting result is taken
// stall
//   while out_ch.ready is low with a result pending, in_ch.ready drops and
//   the state holds, so no result is lost or overwritten
// reset
//   synchronous rst_n: phase idle, counters and timer cleared, drive stop,
//   speed zero, registers back to their reset values, no result pending
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_follow_junction_sequencer_core_assert.svh"

module line_follow_junction_sequencer_core
  import lfjs_pkg::*;
#(
  parameter int COUNT_BITS = 4,
  parameter int TIMER_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  lfjs_in_if.sink                     in_ch,
  lfjs_out_if.source                  out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_FORWARD:     cfg_r.target_forward     <= cfg_data[3:0];
        REG_TARGET_AFTER_RIGHT: cfg_r.target_after_right <= cfg_data[3:0];
        REG_TARGET_MARKERS:     cfg_r.target_markers     <= cfg_data[3:0];
        REG_SPEED_FAST:         cfg_r.speed_fast         <= cfg_data;
        REG_SPEED_SLOW:         cfg_r.speed_slow         <= cfg_data;
        REG_SPIN_SPEED:         cfg_r.spin_speed         <= cfg_data;
        REG_SPEED_FLOOR:        cfg_r.speed_floor        <= cfg_data;
        REG_BLIND_MS:           cfg_r.blind_ms           <= cfg_data;
        default:                cfg_r                    <= cfg_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer state, doubles as the result register
  // --------------------------------------------------------------------------
  phase_t                phase_r,       phase_nxt;
  logic                  spin_left_r,   spin_left_nxt;
  logic                  marker_mode_r, marker_mode_nxt;
  logic [COUNT_BITS-1:0] mark_count_r,  mark_count_nxt;
  logic                  on_mark_r,     on_mark_nxt;
  logic [3:0]            run_target_r,  run_target_nxt;
  logic [7:0]            run_start_r,   run_start_nxt;
  logic [TIMER_BITS-1:0] ms_timer_r,    ms_timer_nxt;
  drive_t                last_drive_r,  last_drive_nxt;
  logic [7:0]            last_speed_r,  last_speed_nxt;
  logic                  aborted_r,     aborted_nxt;
  logic                  out_valid_r;

  logic accept;

  // the output side frees up either when empty or when taken this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // per-tick helper terms
  // --------------------------------------------------------------------------
  logic [2:0]            pat;
  logic                  estop;
  logic                  junction;
  logic                  seen;
  logic [TIMER_BITS-1:0] timer_inc;
  logic                  blind_done;
  logic                  settle_done;
  logic                  center_done;
  logic [COUNT_BITS-1:0] count_sat;
  logic                  count_hit;
  logic [3:0]            settle_target;
  drive_t                spin_drive;
  speed_pair_t           follow_speed;

  assign pat   = {in_ch.sense_left, in_ch.sense_mid, in_ch.sense_right};
  assign estop = (in_ch.cmd == CMD_ESTOP);

  // markers: mid and right; junctions: all three sensors
  assign junction = marker_mode_r ? (in_ch.sense_mid && in_ch.sense_right)
                                  : (pat == 3'b111);
  assign seen     = spin_left_r ? in_ch.sense_left : in_ch.sense_right;

  // saturating millisecond timer
  assign timer_inc = (in_ch.ms_strobe && (ms_timer_r != '1)) ?
                     ms_timer_r + 1'b1 : ms_timer_r;

  assign blind_done  = timer_inc >= TIMER_BITS'(cfg_r.blind_ms);
  assign settle_done = timer_inc >= TIMER_BITS'(SETTLE_MS);
  assign center_done = timer_inc >= TIMER_BITS'(CENTER_MS);

  // saturating count, target reached when at or above it
  assign count_sat = (mark_count_r == '1) ? mark_count_r : mark_count_r + 1'b1;
  assign count_hit = junction && !on_mark_r && (8'(count_sat) >= 8'(run_target_r));

  assign settle_target = spin_left_r ? cfg_r.target_markers : cfg_r.target_after_right;
  assign spin_drive    = spin_left_r ? DR_LEFT : DR_RIGHT;

  lfjs_speed #(
    .COUNT_BITS (COUNT_BITS)
  ) u_speed (
    .start_speed (run_start_r),
    .floor_speed (cfg_r.speed_floor),
    .count       (mark_count_r),
    .speeds      (follow_speed)
  );

  // --------------------------------------------------------------------------
  // next phase
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_ch.cmd == CMD_FWD) begin
          phase_nxt = (cfg_r.target_forward == 4'd0) ? PH_CENTER : PH_FOLLOW;
        end else if ((in_ch.cmd == CMD_RIGHT) || (in_ch.cmd == CMD_LEFT)) begin
          phase_nxt = (cfg_r.blind_ms == 8'd0) ? PH_SEEK : PH_BLIND;
        end
      end
      PH_BLIND: begin
        priority if (estop)   phase_nxt = PH_IDLE;
        else if (blind_done)  phase_nxt = PH_SEEK;
      end
      PH_SEEK: begin
        priority if (estop)   phase_nxt = PH_IDLE;
        else if (seen)        phase_nxt = PH_SETTLE;
      end
      PH_SETTLE: begin
        if (settle_done) begin
          phase_nxt = (settle_target == 4'd0) ? PH_CENTER : PH_FOLLOW;
        end
      end
      PH_FOLLOW: begin
        // reaching the target on this tick wins over the e-stop
        priority if (count_hit) phase_nxt = PH_CENTER;
        else if (estop)         phase_nxt = PH_IDLE;
      end
      PH_CENTER: begin
        if (center_done) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and outputs of the sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    spin_left_nxt   = spin_left_r;
    marker_mode_nxt = marker_mode_r;
    mark_count_nxt  = mark_count_r;
    on_mark_nxt     = on_mark_r;
    run_target_nxt  = run_target_r;
    run_start_nxt   = run_start_r;
    ms_timer_nxt    = ms_timer_r;
    last_drive_nxt  = last_drive_r;
    last_speed_nxt  = last_speed_r;
    aborted_nxt     = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_ch.cmd == CMD_FWD) begin
          // start a forward run, drive held on the start tick unless the target is zero
          mark_count_nxt  = '0;
          on_mark_nxt     = 1'b1;
          run_target_nxt  = cfg_r.target_forward;
          run_start_nxt   = cfg_r.speed_fast;
          marker_mode_nxt = 1'b0;
          ms_timer_nxt    = '0;
          if (cfg_r.target_forward == 4'd0) begin
            last_drive_nxt = DR_ADV;
            last_speed_nxt = cfg_r.speed_floor;
          end
        end else if ((in_ch.cmd == CMD_RIGHT) || (in_ch.cmd == CMD_LEFT)) begin
          // rotation starts at once
          spin_left_nxt  = (in_ch.cmd == CMD_LEFT);
          mark_count_nxt = '0;
          ms_timer_nxt   = '0;
          last_drive_nxt = (in_ch.cmd == CMD_LEFT) ? DR_LEFT : DR_RIGHT;
          last_speed_nxt = cfg_r.spin_speed;
        end
      end
      PH_BLIND: begin
        if (estop) begin
          last_drive_nxt = DR_STOP;
          aborted_nxt    = 1'b1;
        end else begin
          last_drive_nxt = spin_drive;
          last_speed_nxt = cfg_r.spin_speed;
          ms_timer_nxt   = blind_done ? '0 : timer_inc;
        end
      end
      PH_SEEK: begin
        if (estop) begin
          last_drive_nxt = DR_STOP;
          aborted_nxt    = 1'b1;
        end else begin
          last_speed_nxt = cfg_r.spin_speed;
          if (seen) begin
            last_drive_nxt = DR_STOP;
            ms_timer_nxt   = '0;
          end else begin
            last_drive_nxt = spin_drive;
          end
        end
      end
      PH_SETTLE: begin
        last_drive_nxt = DR_STOP;
        ms_timer_nxt   = timer_inc;
        if (settle_done) begin
          mark_count_nxt  = '0;
          on_mark_nxt     = 1'b1;
          run_target_nxt  = settle_target;
          run_start_nxt   = cfg_r.speed_slow;
          marker_mode_nxt = spin_left_r;
          ms_timer_nxt    = '0;
          if (settle_target == 4'd0) begin
            last_drive_nxt = DR_ADV;
            last_speed_nxt = cfg_r.speed_floor;
          end
        end
      end
      PH_FOLLOW: begin
        if (junction) begin
          // count only on entry to a junction
          if (!on_mark_r) begin
            mark_count_nxt = count_sat;
            on_mark_nxt    = 1'b1;
          end
          if (count_hit) begin
            ms_timer_nxt   = '0;
            last_drive_nxt = DR_ADV;
            last_speed_nxt = cfg_r.speed_floor;
          end else begin
            last_drive_nxt = DR_ADV;
            last_speed_nxt = follow_speed.cur;
          end
        end else if (pat != 3'b101) begin
          // left and right without mid holds everything but an e-stop
          on_mark_nxt = 1'b0;
          unique case (pat)
            3'b000, 3'b010: begin
              last_drive_nxt = DR_ADV;
              last_speed_nxt = follow_speed.cur;
            end
            3'b001, 3'b011: begin
              last_drive_nxt = DR_RIGHT;
              last_speed_nxt = follow_speed.boosted;
            end
            default: begin
              last_drive_nxt = DR_LEFT;
              last_speed_nxt = follow_speed.boosted;
            end
          endcase
        end
        if (!count_hit && estop) begin
          last_drive_nxt = DR_STOP;
          aborted_nxt    = 1'b1;
        end
      end
      PH_CENTER: begin
        last_drive_nxt = DR_ADV;
        last_speed_nxt = cfg_r.speed_floor;
        ms_timer_nxt   = timer_inc;
        if (center_done) begin
          last_drive_nxt = DR_STOP;
          ms_timer_nxt   = '0;
        end
      end
      default: last_drive_nxt = DR_STOP;
    endcase
  end

  // --------------------------------------------------------------------------
  // state update, one tick per accepted item
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      spin_left_r   <= 1'b0;
      marker_mode_r <= 1'b0;
      mark_count_r  <= '0;
      on_mark_r     <= 1'b1;
      run_target_r  <= 4'd0;
      run_start_r   <= 8'd0;
      ms_timer_r    <= '0;
      last_drive_r  <= DR_STOP;
      last_speed_r  <= 8'd0;
      aborted_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        spin_left_r   <= spin_left_nxt;
        marker_mode_r <= marker_mode_nxt;
        mark_count_r  <= mark_count_nxt;
        on_mark_r     <= on_mark_nxt;
        run_target_r  <= run_target_nxt;
        run_start_r   <= run_start_nxt;
        ms_timer_r    <= ms_timer_nxt;
        last_drive_r  <= last_drive_nxt;
        last_speed_r  <= last_speed_nxt;
        aborted_r     <= aborted_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result straight from the updated state
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive       = last_drive_r;
  assign out_ch.drive_speed = last_speed_r;
  assign out_ch.phase_now   = phase_r;
  assign out_ch.crossed     = 4'(mark_count_r);
  assign out_ch.aborted     = aborted_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an abort always lands in idle with the drive stopped
  `LFJS_ASSERT(a_abort_idle, clk, rst_n, aborted_r,
               (phase_r == PH_IDLE) && (last_drive_r == DR_STOP))
  // a zero target never reaches follow
  `LFJS_ASSERT(a_follow_target, clk, rst_n, phase_r == PH_FOLLOW, run_target_r != 4'd0)
  // centering always advances
  `LFJS_ASSERT(a_center_adv, clk, rst_n, phase_r == PH_CENTER, last_drive_r == DR_ADV)
  // forward command from idle with a target enters follow
  `LFJS_ASSERT_NXT(a_fwd_start, clk, rst_n,
                   accept && (phase_r == PH_IDLE) && (in_ch.cmd == CMD_FWD) &&
                   (cfg_r.target_forward != 4'd0),
                   phase_r == PH_FOLLOW)

endmodule

`default_nettype wire

/* tb/lfjs_sequence_checker.sv */
// ----------------------------------------------------------------------------
// lfjs_sequence_checker
// follows every sensor tick into a local copy of the run sequencer, keeps
// the drive results it owes and compares them with the result channel
// ----------------------------------------------------------------------------
module lfjs_sequence_checker
  import lfjs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  lfjs_in_if                     in_ch,
  lfjs_out_if                    out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     outstanding,
  output phase_t                 seq_phase
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] PAT_ALL   = 3'b111;
  localparam logic [2:0] PAT_SIDES = 3'b101;

  typedef struct packed {
    drive_t     drive;
    logic [7:0] speed;
    phase_t     phase;
    logic [3:0] crossed;
    logic       aborted;
  } motion_t;

  cfg_t       regs;
  phase_t     phase;
  drive_t     last_drive;
  logic       spin_left, marker_mode, on_mark;
  logic [3:0] mark_count, run_target;
  logic [7:0] run_start_speed, ms_timer, last_speed;

  motion_t expected_motion_q[$];
  motion_t want, got;

  task automatic bump_timer(input logic strobe);
    if (strobe && ms_timer != 8'hFF) ms_timer++;
  endtask

  task automatic enter_center();
    phase      = PH_CENTER;
    ms_timer   = '0;
    last_drive = DR_ADV;
    last_speed = regs.speed_floor;
  endtask

  task automatic start_follow(input logic [3:0] target, input logic [7:0] start,
                              input logic markers);
    mark_count      = '0;
    on_mark         = 1'b1;
    run_target      = target;
    run_start_speed = start;
    marker_mode     = markers;
    ms_timer        = '0;
    if (target == 0) enter_center();
    else phase = PH_FOLLOW;
  endtask

  task automatic stop_to_idle();
    phase      = PH_IDLE;
    last_drive = DR_STOP;
  endtask

  task automatic step_sequencer(input logic [2:0] cmd, input logic [2:0] pat,
                                input logic strobe, output motion_t res);
    int         sp;
    logic [7:0] cur, boosted;
    logic       junction, done, abort_now;
    abort_now = 1'b0;
    done      = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (cmd == CMD_FWD) begin
          start_follow(regs.target_forward, regs.speed_fast, 1'b0);
        end else if (cmd == CMD_RIGHT || cmd == CMD_LEFT) begin
          spin_left  = (cmd == CMD_LEFT);
          mark_count = '0;
          ms_timer   = '0;
          last_drive = spin_left ? DR_LEFT : DR_RIGHT;
          last_speed = regs.spin_speed;
          phase      = (regs.blind_ms == 0) ? PH_SEEK : PH_BLIND;
        end
      end
      PH_BLIND: begin
        if (cmd == CMD_ESTOP) begin
          stop_to_idle();
          abort_now = 1'b1;
        end else begin
          last_drive = spin_left ? DR_LEFT : DR_RIGHT;
          last_speed = regs.spin_speed;
          bump_timer(strobe);
          if (ms_timer >= regs.blind_ms) begin
            phase    = PH_SEEK;
            ms_timer = '0;
          end
        end
      end
      PH_SEEK: begin
        if (cmd == CMD_ESTOP) begin
          stop_to_idle();
          abort_now = 1'b1;
        end else begin
          last_speed = regs.spin_speed;
          // left spin ends on the left sensor, right spin on the right one
          if (spin_left ? pat[2] : pat[0]) begin
            last_drive = DR_STOP;
            phase      = PH_SETTLE;
            ms_timer   = '0;
          end else begin
            last_drive = spin_left ? DR_LEFT : DR_RIGHT;
          end
        end
      end
      PH_SETTLE: begin
        last_drive = DR_STOP;
        bump_timer(strobe);
        if (ms_timer >= SETTLE_MS) begin
          if (spin_left) start_follow(regs.target_markers, regs.speed_slow, 1'b1);
          else start_follow(regs.target_after_right, regs.speed_slow, 1'b0);
        end
      end
      PH_FOLLOW: begin
        sp = int'(run_start_speed) - int'(mark_count) * STEP_DOWN;
        if (sp < int'(regs.speed_floor)) sp = int'(regs.speed_floor);
        cur      = sp[7:0];
        boosted  = (int'(cur) + TURN_BOOST > 255) ? 8'hFF : cur + 8'(TURN_BOOST);
        junction = marker_mode ? (pat[1] && pat[0]) : (pat == PAT_ALL);
        if (junction) begin
          if (!on_mark) begin
            if (mark_count != 4'hF) mark_count++;
            on_mark = 1'b1;
            if (mark_count >= run_target) begin
              enter_center();
              done = 1'b1;
            end
          end
          if (!done) begin
            last_drive = DR_ADV;
            last_speed = cur;
          end
        end else if (pat != PAT_SIDES) begin
          on_mark = 1'b0;
          case (pat)
            3'b000, 3'b010: begin
              last_drive = DR_ADV;
              last_speed = cur;
            end
            3'b001, 3'b011: begin
              last_drive = DR_RIGHT;
              last_speed = boosted;
            end
            default: begin
              last_drive = DR_LEFT;
              last_speed = boosted;
            end
          endcase
        end
        if (!done && cmd == CMD_ESTOP) begin
          stop_to_idle();
          abort_now = 1'b1;
        end
      end
      PH_CENTER: begin
        last_drive = DR_ADV;
        last_speed = regs.speed_floor;
        bump_timer(strobe);
        if (ms_timer >= CENTER_MS) begin
          stop_to_idle();
          ms_timer = '0;
        end
      end
      default: stop_to_idle();
    endcase
    res = '{drive: last_drive, speed: last_speed, phase: phase,
            crossed: mark_count, aborted: abort_now};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs            = CFG_RESET;
      phase           = PH_IDLE;
      last_drive      = DR_STOP;
      spin_left       = 1'b0;
      marker_mode     = 1'b0;
      on_mark         = 1'b1;
      mark_count      = '0;
      run_target      = '0;
      run_start_speed = '0;
      ms_timer        = '0;
      last_speed      = '0;
      expected_motion_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_motion_q.size() == 0) begin
          if (fail_count < 10)
            $display("result with no tick pending: drive %0d speed %0d phase %0d",
                     out_ch.drive, out_ch.drive_speed, out_ch.phase_now);
          fail_count++;
        end else begin
          want = expected_motion_q.pop_front();
          if (out_ch.drive !== want.drive || out_ch.drive_speed !== want.speed ||
              out_ch.phase_now !== want.phase || out_ch.crossed !== want.crossed ||
              out_ch.aborted !== want.aborted) begin
            if (fail_count < 10)
              $display({"mismatch: expected drive %0d speed %0d phase %0d crossed %0d",
                        " aborted %0d, got drive %0d speed %0d phase %0d crossed %0d",
                        " aborted %0d"},
                       want.drive, want.speed, want.phase, want.crossed, want.aborted,
                       out_ch.drive, out_ch.drive_speed, out_ch.phase_now,
                       out_ch.crossed, out_ch.aborted);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        step_sequencer(in_ch.cmd, {in_ch.sense_left, in_ch.sense_mid, in_ch.sense_right},
                       in_ch.ms_strobe, got);
        expected_motion_q.push_back(got);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_FORWARD:     regs.target_forward     = cfg_data[3:0];
          REG_TARGET_AFTER_RIGHT: regs.target_after_right = cfg_data[3:0];
          REG_TARGET_MARKERS:     regs.target_markers     = cfg_data[3:0];
          REG_SPEED_FAST:         regs.speed_fast         = cfg_data;
          REG_SPEED_SLOW:         regs.speed_slow         = cfg_data;
          REG_SPIN_SPEED:         regs.spin_speed         = cfg_data;
          REG_SPEED_FLOOR:        regs.speed_floor        = cfg_data;
          REG_BLIND_MS:           regs.blind_ms           = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_motion_q.size();
    seq_phase   = phase;
  end

endmodule

/* tb/line_follow_junction_sequencer_core_tb.sv */
// ----------------------------------------------------------------------------
// line_follow_junction_sequencer_core_tb
// drives sensor ticks, settings and result back-pressure into the sequencer;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module line_follow_junction_sequencer_core_tb;
  import lfjs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // commands the block has no meaning for
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // ticks for the whole run, directed ones included
  localparam int TICK_BUDGET = 650;
  // no handshake on either side for this long means the block is stuck
  localparam int STUCK_LIMIT  = 1000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int     fail_count;
  int     outstanding;
  phase_t seq_phase;
  bit     quiet = 1'b0;    // when set, neither side idles
  int     ticks_sent = 0;
  int     stuck_cycles = 0;

  lfjs_in_if  in_ch();
  lfjs_out_if out_ch();

  line_follow_junction_sequencer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lfjs_sequence_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .seq_phase   (seq_phase)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] any_pattern();
    return 3'($urandom_range(0, 7));
  endfunction

  // a command that is mostly none but now and then anything at all
  function automatic logic [2:0] stray_cmd();
    return coin(5) ? 3'($urandom_range(0, 7)) : CMD_NONE;
  endfunction

  // follow patterns lean toward junctions and markers so runs reach their target
  function automatic logic [2:0] follow_pattern();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 3'b111;
    if (r < 30) return 3'b011;
    if (r < 38) return 3'b101;
    return any_pattern();
  endfunction

  function automatic logic [3:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 4'd0;
    if (r < 16) return 4'd15;
    return 4'($urandom_range(1, 6));
  endfunction

  function automatic logic [7:0] pick_speed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd0;
    if (r < 16) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_blind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'd255;
    if (r < 20) return 8'd0;
    return 8'($urandom_range(1, 12));
  endfunction

  // called at a falling edge; returns at a falling edge after the item is taken
  // with valid low, so a caller that sends nothing more never repeats the item
  task automatic send_tick(input logic [2:0] cmd, input logic [2:0] pat,
                           input logic strobe);
    int gap;
    in_ch.cmd         = cmd;
    in_ch.sense_left  = pat[2];
    in_ch.sense_mid   = pat[1];
    in_ch.sense_right = pat[0];
    in_ch.ms_strobe   = strobe;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
    gap = pick_gap();
    if (gap > 0) begin
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // settings change only once every owed result is out and the block is quiet
  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // keep feeding ticks that suit the current phase until the run is over
  task automatic run_until_idle();
    while (seq_phase != PH_IDLE) begin
      case (seq_phase)
        PH_BLIND:
          send_tick(coin(3) ? CMD_ESTOP : stray_cmd(), any_pattern(), coin(85));
        PH_SEEK:
          // all dark keeps the spin going a while before a sensor hits
          send_tick(coin(3) ? CMD_ESTOP : stray_cmd(),
                    coin(50) ? 3'b000 : any_pattern(), coin(50));
        PH_FOLLOW:
          send_tick(coin(2) ? CMD_ESTOP : stray_cmd(), follow_pattern(), coin(50));
        default:
          // settle and centering ignore e-stop, so any command may come
          send_tick(stray_cmd(), any_pattern(), coin(88));
      endcase
    end
  endtask

  task automatic random_settings();
    wait_drained();
    write_reg(REG_TARGET_FORWARD,     {4'($urandom_range(0, 15)), pick_target()});
    write_reg(REG_TARGET_AFTER_RIGHT, {4'($urandom_range(0, 15)), pick_target()});
    write_reg(REG_TARGET_MARKERS,     {4'($urandom_range(0, 15)), pick_target()});
    write_reg(REG_SPEED_FAST,   pick_speed());
    write_reg(REG_SPEED_SLOW,   pick_speed());
    write_reg(REG_SPIN_SPEED,   pick_speed());
    write_reg(REG_SPEED_FLOOR,  pick_speed());
    write_reg(REG_BLIND_MS,     pick_blind());
  endtask

  // one session: a forward run, a rotation run or a burst of noise
  task automatic random_session();
    int r, n;
    quiet = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 15) begin
      n = $urandom_range(3, 10);
      repeat (n) send_tick(3'($urandom_range(0, 7)), any_pattern(), coin(50));
    end else if (r < 55) begin
      send_tick(CMD_FWD, any_pattern(), coin(50));
    end else begin
      send_tick(coin(50) ? CMD_LEFT : CMD_RIGHT, any_pattern(), coin(50));
    end
    run_until_idle();
  endtask

  // result side: ready with random stalls, unless quiet
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_ch.ready = 1'b1;
        stall = 0;
      end else if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        if (coin(25)) stall = pick_gap();
      end
    end
  end

  // watchdog on handshakes of either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int last_settings;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_NONE;
    in_ch.sense_left  = 1'b0;
    in_ch.sense_mid   = 1'b0;
    in_ch.sense_right = 1'b0;
    in_ch.ms_strobe   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: idle ticks, spare commands and e-stop all leave idle alone
    send_tick(CMD_NONE, 3'b111, 1'b1);
    send_tick(CMD_SPARE_5, 3'b101, 1'b0);
    send_tick(CMD_SPARE_6, 3'b010, 1'b1);
    send_tick(CMD_SPARE_7, 3'b000, 1'b0);
    send_tick(CMD_ESTOP, 3'b000, 1'b0);

    // low extremes; the target byte has upper bits set that must drop out,
    // leaving a zero target that goes straight to centering
    wait_drained();
    write_reg(REG_TARGET_FORWARD,     8'hF0);
    write_reg(REG_TARGET_AFTER_RIGHT, 8'h01);
    write_reg(REG_TARGET_MARKERS,     8'h01);
    write_reg(REG_SPEED_FAST,   8'd0);
    write_reg(REG_SPEED_SLOW,   8'd0);
    write_reg(REG_SPIN_SPEED,   8'd0);
    write_reg(REG_SPEED_FLOOR,  8'd0);
    write_reg(REG_BLIND_MS,     8'd0);
    send_tick(CMD_FWD, 3'b010, 1'b1);
    send_tick(CMD_ESTOP, 3'b111, 1'b1);    // no effect while centering
    run_until_idle();

    // full speed so a correction saturates; each kind of follow pattern at least once
    wait_drained();
    write_reg(REG_TARGET_FORWARD, 8'h02);
    write_reg(REG_SPEED_FAST,     8'hFF);
    send_tick(CMD_FWD, 3'b000, 1'b0);      // drive held on the start tick
    send_tick(CMD_NONE, 3'b000, 1'b0);
    send_tick(CMD_NONE, 3'b001, 1'b0);
    send_tick(CMD_NONE, 3'b110, 1'b0);
    send_tick(CMD_NONE, 3'b101, 1'b0);     // sides without middle hold the drive
    send_tick(CMD_NONE, 3'b111, 1'b0);
    send_tick(CMD_NONE, 3'b111, 1'b0);     // still on the same junction
    send_tick(CMD_NONE, 3'b010, 1'b0);
    send_tick(CMD_ESTOP, 3'b111, 1'b1);    // last junction beats the e-stop
    run_until_idle();
    send_tick(CMD_FWD, 3'b000, 1'b1);
    send_tick(CMD_ESTOP, 3'b000, 1'b1);    // abort while following

    // left rotation with no blind time, busy commands ignored, e-stop in settle
    send_tick(CMD_LEFT, 3'b000, 1'b1);
    send_tick(CMD_NONE, 3'b001, 1'b1);
    send_tick(CMD_RIGHT, 3'b000, 1'b1);
    send_tick(CMD_NONE, 3'b100, 1'b1);
    send_tick(CMD_ESTOP, 3'b000, 1'b1);
    run_until_idle();
    send_tick(CMD_RIGHT, 3'b000, 1'b1);
    send_tick(CMD_ESTOP, 3'b001, 1'b1);    // abort while seeking

    // high extremes: abort in blind spin, then a fifteen junction run
    wait_drained();
    write_reg(REG_TARGET_FORWARD,     8'h0F);
    write_reg(REG_TARGET_AFTER_RIGHT, 8'hFF);
    write_reg(REG_TARGET_MARKERS,     8'h0F);
    write_reg(REG_SPEED_SLOW,   8'hFF);
    write_reg(REG_SPIN_SPEED,   8'hFF);
    write_reg(REG_SPEED_FLOOR,  8'hFF);
    write_reg(REG_BLIND_MS,     8'hFF);
    send_tick(CMD_RIGHT, 3'b000, 1'b1);
    send_tick(CMD_NONE, 3'b000, 1'b1);
    send_tick(CMD_ESTOP, 3'b000, 1'b1);
    send_tick(CMD_FWD, 3'b000, 1'b1);
    run_until_idle();

    // random sessions with fresh settings every so often, at least one
    last_settings = ticks_sent;
    random_settings();
    do begin
      random_session();
      if (ticks_sent - last_settings >= 150) begin
        random_settings();
        last_settings = ticks_sent;
      end
    end while (ticks_sent < TICK_BUDGET);
    quiet = 1'b0;

    // let every owed result come out before the run ends
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
